@@ hdl/dcsq_pkg.sv @@
// Types and constants shared by the disk command slot queue.
package dcsq_pkg;

  localparam logic [7:0] DRV_LBA_BASE = 8'hE0;

  typedef enum logic [1:0] {
    STAT_ENQ   = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_TAKEN = 2'd2,
    STAT_EMPTY = 2'd3
  } stat_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAKE,
    ST_SCAN
  } state_e;

  typedef enum logic {
    OP_ENQ  = 1'b0,
    OP_TAKE = 1'b1
  } op_e;

  typedef struct packed {
    logic        wr;
    logic [31:0] buf_addr;
    logic [27:0] lba;
    logic [31:0] process;
  } cmd_t;

endpackage

@@ hdl/dcsq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dcsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ hdl/disk_command_slot_queue.sv @@
// Disk command queue: linked list of commands in a fixed slot table.
// Enqueue: result word in the cycle after start, then a free-slot scan of
// 8 slots per cycle, busy until a free slot or the last group is reached.
// Take: command/link RAM read, then result. Full/empty: no scan, no busy.
// The result strobe done_o lasts one cycle and cannot be stalled.
// Reset (async, active low) empties the queue at once; no clearing pass.
module disk_command_slot_queue
  import dcsq_pkg::*;
#(
  parameter int SLOT_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic        write_request_i,
  input  logic [31:0] buffer_address_i,
  input  logic [27:0] sector_lba_i,
  input  logic [31:0] waiting_process_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [7:0]  slot_o,
  output logic        out_write_o,
  output logic [31:0] out_buffer_address_o,
  output logic [27:0] out_lba_o,
  output logic [31:0] out_process_o,
  output logic        wake_needed_o,
  output logic [7:0]  drive_head_byte_o
);

  localparam int IW      = $clog2(SLOT_COUNT);
  localparam int NCH     = (SLOT_COUNT + 7) / 8;
  localparam int UW      = NCH * 8;
  localparam int CPW     = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int CMDW    = $bits(cmd_t);
  localparam logic [CPW-1:0] LAST_CH = CPW'(NCH - 1);

  state_e           state_q, state_d;
  logic [UW-1:0]    used_q;
  logic [IW-1:0]    free_q;
  logic             free_vld_q;
  logic [IW-1:0]    tail_q;
  logic [IW-1:0]    head_q;
  logic [CPW-1:0]   scan_q;
  logic             done_q;

  stat_e            res_status_q;
  logic [7:0]       res_slot_q;
  cmd_t             res_cmd_q;
  logic             res_wake_q;
  logic [7:0]       res_dh_q;

  logic             accept;
  logic             do_enq;
  logic             do_take;
  logic [7:0]       chunk;
  logic             zero_any;
  logic [2:0]       zero_pos;
  logic [IW-1:0]    found_idx;
  logic             nonempty;

  cmd_t             cmd_wdata;
  logic [CMDW-1:0]  cmd_rraw;
  cmd_t             cmd_rdata;
  logic [IW-1:0]    link_rdata;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign nonempty = (tail_q != '0);
  assign do_enq   = accept && (operation_i == OP_ENQ) && free_vld_q;
  assign do_take  = accept && (operation_i == OP_TAKE) && nonempty;

  assign cmd_wdata = '{wr: write_request_i, buf_addr: buffer_address_i,
                       lba: sector_lba_i, process: waiting_process_i};
  assign cmd_rdata = cmd_t'(cmd_rraw);

  dcsq_ram #(.WIDTH(CMDW), .DEPTH(SLOT_COUNT)) u_cmd_ram (
    .clk_i   (clk_i),
    .we_i    (do_enq),
    .waddr_i (free_q),
    .wdata_i (cmd_wdata),
    .re_i    (do_take),
    .raddr_i (head_q),
    .rdata_o (cmd_rraw)
  );

  dcsq_ram #(.WIDTH(IW), .DEPTH(SLOT_COUNT)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (do_enq && nonempty),
    .waddr_i (tail_q),
    .wdata_i (free_q),
    .re_i    (do_take),
    .raddr_i (head_q),
    .rdata_o (link_rdata)
  );

  // free-slot scan over one group of eight slots
  always_comb begin
    chunk    = used_q[int'(scan_q) * 8 +: 8];
    zero_any = ~&chunk;
    zero_pos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!chunk[i]) begin
        zero_pos = 3'(i);
      end
    end
    found_idx = IW'({scan_q, zero_pos});
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (do_enq) begin
          state_d = ST_SCAN;
        end else if (do_take) begin
          state_d = ST_TAKE;
        end
      end
      ST_TAKE: state_d = ST_IDLE;
      ST_SCAN: begin
        if (zero_any || scan_q == LAST_CH) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < UW; i++) begin
        used_q[i] <= (i == 0) || (i >= SLOT_COUNT);
      end
      free_q     <= IW'(1);
      free_vld_q <= 1'b1;
      tail_q     <= '0;
      head_q     <= '0;
      scan_q     <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= accept || (state_q == ST_TAKE);
      if (do_enq) begin
        used_q[free_q] <= 1'b1;
        tail_q         <= free_q;
        free_vld_q     <= 1'b0;
        scan_q         <= CPW'(free_q >> 3);
        if (!nonempty) begin
          head_q <= free_q;
        end
      end
      if (state_q == ST_SCAN) begin
        if (zero_any) begin
          free_q     <= found_idx;
          free_vld_q <= 1'b1;
        end else if (scan_q != LAST_CH) begin
          scan_q <= scan_q + CPW'(1);
        end
      end
      if (state_q == ST_TAKE) begin
        used_q[head_q] <= 1'b0;
        if (!free_vld_q || head_q < free_q) begin
          free_q     <= head_q;
          free_vld_q <= 1'b1;
        end
        if (head_q == tail_q) begin
          tail_q <= '0;
        end else begin
          head_q <= link_rdata;
        end
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_cmd_q  <= '0;
      res_wake_q <= 1'b0;
      res_dh_q   <= '0;
      if (operation_i == OP_ENQ) begin
        if (free_vld_q) begin
          res_status_q <= STAT_ENQ;
          res_slot_q   <= 8'(free_q);
        end else begin
          res_status_q <= STAT_FULL;
          res_slot_q   <= '0;
        end
      end else begin
        res_status_q <= nonempty ? STAT_TAKEN : STAT_EMPTY;
        res_slot_q   <= '0;
      end
    end else if (state_q == ST_TAKE) begin
      res_status_q <= STAT_TAKEN;
      res_slot_q   <= 8'(head_q);
      res_cmd_q    <= cmd_rdata;
      res_wake_q   <= (cmd_rdata.process != '0);
      res_dh_q     <= DRV_LBA_BASE | {4'b0000, cmd_rdata.lba[27:24]};
    end
  end

  assign done_o               = done_q && !(res_status_q == STAT_TAKEN && busy);
  assign status_o             = res_status_q;
  assign slot_o               = res_slot_q;
  assign out_write_o          = res_cmd_q.wr;
  assign out_buffer_address_o = res_cmd_q.buf_addr;
  assign out_lba_o            = res_cmd_q.lba;
  assign out_process_o        = res_cmd_q.process;
  assign wake_needed_o        = res_wake_q;
  assign drive_head_byte_o    = res_dh_q;

  a_take_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_TAKE |=> done_o && status_o == STAT_TAKEN)
    else $error("take did not deliver a result word");

  a_free_is_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_vld_q && state_q == ST_IDLE |-> !used_q[free_q] && free_q != '0)
    else $error("free slot pointer names a used slot");

  a_sentinel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q[0] && !(nonempty && !used_q[tail_q]))
    else $error("sentinel freed or tail slot not in use");

endmodule
